[rtl/i2cra_pkg.sv]
// Package for the I2C register access master.
// Item types, request and operation codes, frame timing, and the bus phase decode record.
// Used by i2cra_phase_dec, i2cra_core and i2c_register_access_master.
`default_nettype none

package i2cra_pkg;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  // Frame timing in ticks
  localparam logic [6:0] T_FRAME1     = 7'd19;
  localparam logic [6:0] T_FRAME2     = 7'd37;
  localparam logic [6:0] T_FRAME3     = 7'd55;
  localparam logic [6:0] T_WR_END_ONE = 7'd55;
  localparam logic [6:0] T_WR_END_TWO = 7'd73;
  localparam logic [6:0] T_RSTART     = 7'd37;
  localparam logic [6:0] T_RD_FRAME2  = 7'd40;
  localparam logic [6:0] T_RD_FRAME3  = 7'd58;
  localparam logic [6:0] T_RD_FRAME4  = 7'd76;
  localparam logic [6:0] T_RD_STOP    = 7'd94;

  typedef enum logic [1:0] {
    OP_IDLE  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_FRAME  = 2'd1,
    PH_RSTART = 2'd2,
    PH_STOP   = 2'd3
  } phase_e;

  typedef struct packed {
    phase_e      kind;
    logic [2:0]  frame;    // byte frame index
    logic [3:0]  bit_idx;  // 0..7 data bits, 8 ack slot
    logic        high;     // SCL high half of the bit
    logic [1:0]  step;     // step within repeated start or stop, saturates at 2
  } phase_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] dev_addr;
    logic [7:0] reg_index;
    logic [7:0] data_high;
    logic [7:0] data_low;
    logic       two_bytes;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic        scl_level;
    logic        sda_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;
    logic        nack_seen;
  } out_item_t;

endpackage

`default_nettype wire

[rtl/i2cra_phase_dec.sv]
// Bus phase decoder: maps the tick count of a transaction to its phase.
// Depends on i2cra_pkg.
`default_nettype none

module i2cra_phase_dec
  import i2cra_pkg::*;
(
  input  var op_e        op_i,
  input  var logic [6:0] tick_i,
  input  var logic       two_bytes_i,
  output var phase_t     phase_o
);

  logic [6:0] base;
  logic [6:0] fend;
  logic [6:0] rel;
  logic [6:0] stop_rel;

  always_comb begin
    phase_o  = '0;
    base     = '0;
    fend     = two_bytes_i ? T_WR_END_TWO : T_WR_END_ONE;
    stop_rel = '0;
    phase_o.kind = PH_START;
    if (tick_i == 7'd0) begin
      phase_o.kind = PH_START;
    end else if (op_i == OP_WRITE) begin
      if (tick_i < fend) begin
        phase_o.kind = PH_FRAME;
        priority if (tick_i < T_FRAME1) begin
          phase_o.frame = 3'd0; base = 7'd1;
        end else if (tick_i < T_FRAME2) begin
          phase_o.frame = 3'd1; base = T_FRAME1;
        end else if (tick_i < T_FRAME3) begin
          phase_o.frame = 3'd2; base = T_FRAME2;
        end else begin
          phase_o.frame = 3'd3; base = T_FRAME3;
        end
      end else begin
        phase_o.kind = PH_STOP;
        stop_rel     = tick_i - fend;
      end
    end else begin
      priority if (tick_i < T_FRAME1) begin
        phase_o.kind = PH_FRAME; phase_o.frame = 3'd0; base = 7'd1;
      end else if (tick_i < T_RSTART) begin
        phase_o.kind = PH_FRAME; phase_o.frame = 3'd1; base = T_FRAME1;
      end else if (tick_i < T_RD_FRAME2) begin
        phase_o.kind = PH_RSTART;
        stop_rel     = tick_i - T_RSTART;
      end else if (tick_i < T_RD_FRAME3) begin
        phase_o.kind = PH_FRAME; phase_o.frame = 3'd2; base = T_RD_FRAME2;
      end else if (tick_i < T_RD_FRAME4) begin
        phase_o.kind = PH_FRAME; phase_o.frame = 3'd3; base = T_RD_FRAME3;
      end else if (tick_i < T_RD_STOP) begin
        phase_o.kind = PH_FRAME; phase_o.frame = 3'd4; base = T_RD_FRAME4;
      end else begin
        phase_o.kind = PH_STOP;
        stop_rel     = tick_i - T_RD_STOP;
      end
    end
    rel             = tick_i - base;
    phase_o.bit_idx = rel[4:1];
    phase_o.high    = rel[0];
    phase_o.step    = (stop_rel >= 7'd2) ? 2'd2 : stop_rel[1:0];
  end

endmodule

`default_nettype wire

[rtl/i2cra_core.sv]
// Transaction state and one-phase-per-tick update of the I2C master.
// Depends on i2cra_pkg and i2cra_phase_dec.
`default_nettype none

module i2cra_core
  import i2cra_pkg::*;
(
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      fire_i,
  input  var in_item_t  item_i,
  output var out_item_t result_o
);

  op_e         op_q, op_d;
  logic [6:0]  phase_q, phase_d;
  logic [15:0] shift_q, shift_d;
  logic [6:0]  dev_q, dev_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  dh_q, dh_d;
  logic [7:0]  dl_q, dl_d;
  logic        two_q, two_d;
  logic        scl_q, scl_d;
  logic        sda_q, sda_d;
  logic        nack_q, nack_d;
  logic        done;
  logic        rx;
  logic [7:0]  tx_byte;
  phase_t      ph;

  i2cra_phase_dec u_phase_dec (
    .op_i        (op_q),
    .tick_i      (phase_q),
    .two_bytes_i (two_q),
    .phase_o     (ph)
  );

  // Byte sent in the current frame
  always_comb begin
    priority if (ph.frame == 3'd0) begin
      tx_byte = {dev_q, 1'b0};
    end else if (ph.frame == 3'd1) begin
      tx_byte = reg_q;
    end else if (op_q == OP_READ) begin
      tx_byte = {dev_q, 1'b1};
    end else if (ph.frame == 3'd2) begin
      tx_byte = two_q ? dh_q : dl_q;
    end else begin
      tx_byte = dl_q;
    end
  end

  assign rx = (op_q == OP_READ) && (ph.frame >= 3'd3);

  always_comb begin
    op_d    = op_q;
    phase_d = phase_q;
    shift_d = shift_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    dh_d    = dh_q;
    dl_d    = dl_q;
    two_d   = two_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    nack_d  = nack_q;
    done    = 1'b0;
    unique case (op_q)
      OP_IDLE: begin
        if (item_i.req_type == REQ_WRITE || item_i.req_type == REQ_READ) begin
          op_d    = op_e'(item_i.req_type);
          phase_d = '0;
          dev_d   = item_i.dev_addr;
          reg_d   = item_i.reg_index;
          dh_d    = item_i.data_high;
          dl_d    = item_i.data_low;
          two_d   = item_i.two_bytes;
          nack_d  = 1'b0;
          scl_d   = 1'b1;
          sda_d   = 1'b1;
          if (item_i.req_type == REQ_READ) begin
            shift_d = '0;
          end
        end
      end
      OP_WRITE, OP_READ: begin
        if (item_i.req_type == REQ_TICK) begin
          unique case (ph.kind)
            PH_START: begin
              scl_d = 1'b1;
              sda_d = 1'b0;
            end
            PH_FRAME: begin
              scl_d = ph.high;
              if (ph.bit_idx < 4'd8) begin
                sda_d = rx ? 1'b1 : tx_byte[~ph.bit_idx[2:0]];
              end else begin
                sda_d = rx ? (ph.frame != 3'd3) : 1'b1;
              end
              if (ph.high) begin
                if (ph.bit_idx < 4'd8 && rx) begin
                  shift_d = {shift_q[14:0], item_i.sda_in};
                end else if (ph.bit_idx == 4'd8 && !rx) begin
                  nack_d = nack_q | item_i.sda_in;
                end
              end
            end
            PH_RSTART: begin
              priority if (ph.step == 2'd0) begin
                scl_d = 1'b0; sda_d = 1'b1;
              end else if (ph.step == 2'd1) begin
                scl_d = 1'b1; sda_d = 1'b1;
              end else begin
                scl_d = 1'b1; sda_d = 1'b0;
              end
            end
            PH_STOP: begin
              priority if (ph.step == 2'd0) begin
                scl_d = 1'b0; sda_d = 1'b0;
              end else if (ph.step == 2'd1) begin
                scl_d = 1'b1; sda_d = 1'b0;
              end else begin
                scl_d = 1'b1; sda_d = 1'b1;
                done  = 1'b1;
              end
            end
          endcase
          if (done) begin
            op_d    = OP_IDLE;
            phase_d = '0;
          end else begin
            phase_d = phase_q + 7'd1;
          end
        end
      end
      default: begin
        op_d = OP_IDLE;
      end
    endcase
  end

  always_comb begin
    result_o.scl_level = scl_d;
    result_o.sda_level = sda_d;
    result_o.busy_res  = (op_d != OP_IDLE);
    result_o.done_res  = done;
    result_o.read_data = shift_d;
    result_o.nack_seen = nack_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= OP_IDLE;
      phase_q <= '0;
      shift_q <= '0;
      dev_q   <= '0;
      reg_q   <= '0;
      dh_q    <= '0;
      dl_q    <= '0;
      two_q   <= 1'b0;
      scl_q   <= 1'b1;
      sda_q   <= 1'b1;
      nack_q  <= 1'b0;
    end else if (fire_i) begin
      op_q    <= op_d;
      phase_q <= phase_d;
      shift_q <= shift_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      dh_q    <= dh_d;
      dl_q    <= dl_d;
      two_q   <= two_d;
      scl_q   <= scl_d;
      sda_q   <= sda_d;
      nack_q  <= nack_d;
    end
  end

endmodule

`default_nettype wire

[rtl/i2c_register_access_master.sv]
// Top level of the I2C register access master: input register, core, result register.
// Depends on i2cra_pkg, i2cra_core and i2cra_phase_dec.
//
//   channel | direction | handshake             | item
//   --------+-----------+-----------------------+------------
//   in      | input     | in_valid_i/in_stall_o | in_item_t
//   out     | output    | out_valid_o/out_stall_i | out_item_t
//
// Every input item (request or tick) gives exactly one result item.
// An item passes through the input register and then the result register.
// One item per cycle is sustained while the output does not stall; the phase decode
// and state update are combinational and sit between the two registers.
// Reset leaves the master idle with SCL and SDA released.
// A stall on the output holds the result register and, while that is full, the input register.
`default_nettype none

module i2c_register_access_master
  import i2cra_pkg::*;
(
  input  var logic      clk_i,
  input  var logic      rst_ni,
  input  var logic      in_valid_i,
  output var logic      in_stall_o,
  input  var in_item_t  in_item_i,
  output var logic      out_valid_o,
  input  var logic      out_stall_i,
  output var out_item_t out_item_o
);

  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      out_valid_q;
  out_item_t out_item_q;
  logic      out_free;
  logic      advance;
  out_item_t result;

  // Result register can take a new item when empty or being drained
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  // Input register: load on accept, drop once the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  // Core updates its transaction state only when the item advances
  i2cra_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (advance),
    .item_i   (in_item_q),
    .result_o (result)
  );

  // Result register: hold while stalled, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire
